>>> rtl/core/spcp_pkg.sv
// ----------------------------------------------------------------------------
// spcp_pkg
// Shared constants for the sprite camera projection pipeline.
// ----------------------------------------------------------------------------
package spcp_pkg;

  // Default fixed-point format
  localparam int FRAC_BITS_DEF    = 16;
  localparam int MAP_INT_BITS_DEF = 8;

  // Configuration port
  localparam int CFG_IDX_W = 2;
  localparam int CFG_W     = 12;

  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_WIDTH  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_HEIGHT = CFG_IDX_W'(1);

  localparam logic [CFG_W-1:0] WINDOW_WIDTH_RST  = CFG_W'(640);
  localparam logic [CFG_W-1:0] WINDOW_HEIGHT_RST = CFG_W'(480);

  // Fixed result widths
  localparam int COL_W  = 21;
  localparam int SIZE_W = 16;
  localparam int ROW_W  = 17;
  localparam int SCOL_W = 21;
  localparam int ECOL_W = 22;
  localparam int HALF_W = CFG_W - 1;

endpackage

>>> rtl/core/sprite_camera_projection.sv
// Pipeline: the front stages, then the bit-per-stage dividers (QW quotient bits,
//   QW = max(depth width - 1, 21)), then the output register.
// Throughput: one beat per cycle; the whole pipe advances when the output
//   register is empty or its beat is taken.
// Reset: valid bits clear, window registers return to 640 x 480.
// ----------------------------------------------------------------------------
// sprite_camera_projection
// Camera-space transform and screen projection of one sprite per beat.
// ----------------------------------------------------------------------------
module sprite_camera_projection
  import spcp_pkg::*;
#(
  parameter int FRAC_BITS    = FRAC_BITS_DEF,
  parameter int MAP_INT_BITS = MAP_INT_BITS_DEF,
  localparam int POS_W   = MAP_INT_BITS + FRAC_BITS,
  localparam int VEC_W   = FRAC_BITS + 2,
  localparam int DEPTH_W = MAP_INT_BITS + FRAC_BITS + 2
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  // configuration
  input  logic                      cfg_we_i,
  input  logic [CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [CFG_W-1:0]          cfg_wdata_i,
  // input channel
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic [POS_W-1:0]          sprite_x_i,
  input  logic [POS_W-1:0]          sprite_y_i,
  input  logic [POS_W-1:0]          player_x_i,
  input  logic [POS_W-1:0]          player_y_i,
  input  logic signed [VEC_W-1:0]   dir_x_i,
  input  logic signed [VEC_W-1:0]   dir_y_i,
  input  logic signed [VEC_W-1:0]   plane_x_i,
  input  logic signed [VEC_W-1:0]   plane_y_i,
  // output channel
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic                      visible_o,
  output logic signed [COL_W-1:0]   screen_column_o,
  output logic signed [DEPTH_W-1:0] depth_o,
  output logic [SIZE_W-1:0]         sprite_size_o,
  output logic [SIZE_W-1:0]         start_row_o,
  output logic signed [ROW_W-1:0]   end_row_o,
  output logic [SCOL_W-1:0]         start_column_o,
  output logic signed [ECOL_W-1:0]  end_column_o
);

  localparam int DD_W   = POS_W + 1;
  localparam int PD_W   = 2 * VEC_W;
  localparam int PT_W   = VEC_W + DD_W;
  localparam int DET_W  = PD_W + 1;
  localparam int T_W    = PT_W + 1;
  localparam int DIFF_W = T_W + 1;
  localparam int NUM_A  = T_W + FRAC_BITS;
  localparam int NUM_B  = DIFF_W + HALF_W;
  localparam int NUM_C  = DET_W + CFG_W;
  localparam int NUM_AB = (NUM_A > NUM_B) ? NUM_A : NUM_B;
  localparam int NUM_W  = (NUM_AB > NUM_C) ? NUM_AB : NUM_C;
  localparam int DEN_W  = (T_W > DET_W) ? T_W : DET_W;
  localparam int QW     = (DEPTH_W - 1 > COL_W) ? DEPTH_W - 1 : COL_W;
  localparam int DLAT   = QW + 1;

  localparam logic [QW-1:0] DEPTH_MAX = QW'({(DEPTH_W-1){1'b1}});
  localparam logic [QW-1:0] COL_POS   = QW'({(COL_W-1){1'b1}});
  localparam logic [QW-1:0] COL_NEG   = QW'(1) << (COL_W - 1);
  localparam logic [QW-1:0] SIZE_MAX  = QW'({SIZE_W{1'b1}});

  typedef struct packed {
    logic vis;
    logic neg;
  } side_t;

  // --------------------------------------------------------------------------
  // Window registers
  logic [CFG_W-1:0] win_w_q, win_h_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_w_q <= WINDOW_WIDTH_RST;
      win_h_q <= WINDOW_HEIGHT_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_WINDOW_WIDTH:  win_w_q <= cfg_wdata_i;
        CFG_WINDOW_HEIGHT: win_h_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  logic [HALF_W-1:0] hw, hh;
  assign hw = win_w_q[CFG_W-1:1];
  assign hh = win_h_q[CFG_W-1:1];

  // --------------------------------------------------------------------------
  // Pipe enable: the whole pipe moves when the output slot frees up
  logic en;
  logic out_v_q;
  assign en         = !out_v_q || out_ready_i;
  assign in_ready_o = en;

  logic v1_q, v2_q, v3_q, v4_q, v5_q;
  logic dv_q [DLAT];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
      for (int k = 0; k < DLAT; k++) dv_q[k] <= 1'b0;
      out_v_q <= 1'b0;
    end else if (en) begin
      v1_q <= in_valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
      v5_q <= v4_q;
      dv_q[0] <= v5_q;
      for (int k = 1; k < DLAT; k++) dv_q[k] <= dv_q[k-1];
      out_v_q <= dv_q[DLAT-1];
    end
  end

  // --------------------------------------------------------------------------
  // Stage 1: relative position
  logic signed [DD_W-1:0]  ddx_q, ddy_q;
  logic signed [VEC_W-1:0] vdx_q, vdy_q, vpx_q, vpy_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      ddx_q <= $signed({1'b0, sprite_x_i}) - $signed({1'b0, player_x_i});
      ddy_q <= $signed({1'b0, sprite_y_i}) - $signed({1'b0, player_y_i});
      vdx_q <= dir_x_i;
      vdy_q <= dir_y_i;
      vpx_q <= plane_x_i;
      vpy_q <= plane_y_i;
    end
  end

  // Stage 2: the six products
  logic signed [PD_W-1:0] pd0_q, pd1_q;
  logic signed [PT_W-1:0] px0_q, px1_q, py0_q, py1_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      pd0_q <= vpx_q * vdy_q;
      pd1_q <= vdx_q * vpy_q;
      px0_q <= vdy_q * ddx_q;
      px1_q <= vdx_q * ddy_q;
      py0_q <= vpx_q * ddy_q;
      py1_q <= vpy_q * ddx_q;
    end
  end

  // Stage 3: determinant and camera-space numerators
  logic signed [DET_W-1:0] det_q;
  logic signed [T_W-1:0]   txn_q, tyn_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      det_q <= $signed({pd0_q[PD_W-1], pd0_q}) - $signed({pd1_q[PD_W-1], pd1_q});
      txn_q <= $signed({px0_q[PT_W-1], px0_q}) - $signed({px1_q[PT_W-1], px1_q});
      tyn_q <= $signed({py0_q[PT_W-1], py0_q}) - $signed({py1_q[PT_W-1], py1_q});
    end
  end

  // Stage 4: visibility, magnitudes, column sign
  logic signed [DIFF_W-1:0] diff;
  logic [DET_W-1:0]  ad_q;
  logic [T_W-1:0]    at_q;
  logic [DIFF_W-1:0] adiff_q;
  side_t             sd4_q;

  assign diff = $signed({tyn_q[T_W-1], tyn_q}) - $signed({txn_q[T_W-1], txn_q});

  always_ff @(posedge clk_i) begin
    if (en) begin
      sd4_q.vis <= (det_q != '0) && (tyn_q != '0) && (det_q[DET_W-1] == tyn_q[T_W-1]);
      sd4_q.neg <= diff[DIFF_W-1] != tyn_q[T_W-1];
      ad_q      <= det_q[DET_W-1] ? DET_W'(-det_q) : DET_W'(det_q);
      at_q      <= tyn_q[T_W-1] ? T_W'(-tyn_q) : T_W'(tyn_q);
      adiff_q   <= diff[DIFF_W-1] ? DIFF_W'(-diff) : DIFF_W'(diff);
    end
  end

  // Stage 5: dividends (column and size scaled by window) and divisors
  logic [NUM_W-1:0] nd_q, nc_q, ns_q;
  logic [DEN_W-1:0] dt_q, da_q;
  side_t            sd5_q;
  logic [NUM_B-1:0] nc_prod;
  logic [NUM_C-1:0] ns_prod;

  // full-width products
  assign nc_prod = adiff_q * hw;
  assign ns_prod = ad_q * win_h_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      nd_q  <= NUM_W'({at_q, {FRAC_BITS{1'b0}}});
      nc_q  <= NUM_W'(nc_prod);
      ns_q  <= NUM_W'(ns_prod);
      dt_q  <= DEN_W'(at_q);
      da_q  <= DEN_W'(ad_q);
      sd5_q <= sd4_q;
    end
  end

  // --------------------------------------------------------------------------
  // Dividers: depth, column, size
  logic [QW-1:0] qd, qc, qs;
  logic          od, oc, os;

  spcp_div #(.NUM_W(NUM_W), .DEN_W(DEN_W), .QW(QW)) u_div_depth (
    .clk_i, .en_i(en), .num_i(nd_q), .den_i(da_q), .quo_o(qd), .ovf_o(od)
  );
  spcp_div #(.NUM_W(NUM_W), .DEN_W(DEN_W), .QW(QW)) u_div_col (
    .clk_i, .en_i(en), .num_i(nc_q), .den_i(dt_q), .quo_o(qc), .ovf_o(oc)
  );
  spcp_div #(.NUM_W(NUM_W), .DEN_W(DEN_W), .QW(QW)) u_div_size (
    .clk_i, .en_i(en), .num_i(ns_q), .den_i(dt_q), .quo_o(qs), .ovf_o(os)
  );

  // side info travels beside the dividers
  side_t sdl_q [DLAT];
  always_ff @(posedge clk_i) begin
    if (en) begin
      sdl_q[0] <= sd5_q;
      for (int k = 1; k < DLAT; k++) sdl_q[k] <= sdl_q[k-1];
    end
  end

  // --------------------------------------------------------------------------
  // Final: saturation and draw limits
  side_t                    sdo;
  logic [QW-1:0]            dsat, clim, csat, ssat;
  logic [SIZE_W-1:0]        size;
  logic [SIZE_W-2:0]        half;
  logic signed [COL_W-1:0]  col;
  logic signed [ROW_W-1:0]  srow_t, erow_t;
  logic signed [ECOL_W-1:0] scol_t, ecol_t;

  assign sdo  = sdl_q[DLAT-1];
  assign dsat = (od || qd > DEPTH_MAX) ? DEPTH_MAX : qd;
  assign clim = sdo.neg ? COL_NEG : COL_POS;
  assign csat = (oc || qc > clim) ? clim : qc;
  assign ssat = (os || qs > SIZE_MAX) ? SIZE_MAX : qs;
  assign size = ssat[SIZE_W-1:0];
  assign half = size[SIZE_W-1:1];
  assign col  = sdo.neg ? COL_W'(-$signed(csat[COL_W-1:0])) : $signed(csat[COL_W-1:0]);

  assign srow_t = $signed(ROW_W'(hh)) - $signed(ROW_W'(half));
  assign erow_t = $signed(ROW_W'(hh)) + $signed(ROW_W'(half));
  assign scol_t = ECOL_W'(col) - $signed(ECOL_W'(half));
  assign ecol_t = ECOL_W'(col) + $signed(ECOL_W'(half));

  logic                      vis_q;
  logic signed [COL_W-1:0]   col_q;
  logic signed [DEPTH_W-1:0] depth_q;
  logic [SIZE_W-1:0]         size_q, srow_q;
  logic signed [ROW_W-1:0]   erow_q;
  logic [SCOL_W-1:0]         scol_q;
  logic signed [ECOL_W-1:0]  ecol_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      if (sdo.vis) begin
        vis_q   <= 1'b1;
        col_q   <= col;
        depth_q <= DEPTH_W'(dsat);
        size_q  <= size;
        srow_q  <= srow_t[ROW_W-1] ? '0 : srow_t[SIZE_W-1:0];
        erow_q  <= (erow_t >= $signed(ROW_W'(win_h_q))) ?
                   $signed(ROW_W'(win_h_q)) - ROW_W'(1) : erow_t;
        scol_q  <= scol_t[ECOL_W-1] ? '0 : scol_t[SCOL_W-1:0];
        ecol_q  <= (ecol_t >= $signed(ECOL_W'(win_w_q))) ?
                   $signed(ECOL_W'(win_w_q)) - ECOL_W'(1) : ecol_t;
      end else begin
        vis_q   <= 1'b0;
        col_q   <= '0;
        depth_q <= '0;
        size_q  <= '0;
        srow_q  <= '0;
        erow_q  <= '0;
        scol_q  <= '0;
        ecol_q  <= '0;
      end
    end
  end

  assign out_valid_o     = out_v_q;
  assign visible_o       = vis_q;
  assign screen_column_o = col_q;
  assign depth_o         = depth_q;
  assign sprite_size_o   = size_q;
  assign start_row_o     = srow_q;
  assign end_row_o       = erow_q;
  assign start_column_o  = scol_q;
  assign end_column_o    = ecol_q;

endmodule

>>> rtl/core/spcp_div.sv
// ----------------------------------------------------------------------------
// spcp_div
// Pipelined restoring divider: one quotient bit per stage, plus an overflow
// flag that is set when the quotient does not fit in QW bits.
// ----------------------------------------------------------------------------
module spcp_div #(
  parameter int NUM_W = 60,
  parameter int DEN_W = 44,
  parameter int QW    = 25
) (
  input  logic             clk_i,
  input  logic             en_i,
  input  logic [NUM_W-1:0] num_i,
  input  logic [DEN_W-1:0] den_i,
  output logic [QW-1:0]    quo_o,
  output logic             ovf_o
);

  localparam int CMP_W = ((NUM_W > DEN_W + QW) ? NUM_W : DEN_W + QW) + 1;

  logic [NUM_W-1:0] rem_q [QW+1];
  logic [DEN_W-1:0] den_q [QW+1];
  logic [QW-1:0]    quo_q [QW+1];
  logic             ovf_q [QW+1];

  logic [CMP_W-1:0] top_lim;
  assign top_lim = CMP_W'(den_i) << QW;

  // Entry stage: overflow check against den << QW
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0] <= num_i;
      den_q[0] <= den_i;
      quo_q[0] <= '0;
      ovf_q[0] <= (CMP_W'(num_i) >= top_lim);
    end
  end

  // One quotient bit per stage, MSB first
  for (genvar k = 1; k <= QW; k++) begin : g_step
    logic [CMP_W-1:0] sh;
    logic [CMP_W-1:0] rx;
    logic             ge;
    assign sh = CMP_W'(den_q[k-1]) << (QW - k);
    assign rx = CMP_W'(rem_q[k-1]);
    assign ge = (rx >= sh);

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k] <= ge ? NUM_W'(rx - sh) : rem_q[k-1];
        den_q[k] <= den_q[k-1];
        quo_q[k] <= quo_q[k-1] | (ge ? (QW'(1) << (QW - k)) : '0);
        ovf_q[k] <= ovf_q[k-1];
      end
    end
  end

  assign quo_o = quo_q[QW];
  assign ovf_o = ovf_q[QW];

endmodule
